>>> hdl/rlbc_pkg.sv
// shared types and constants of the run-length byte codec
package rlbc_pkg;

    localparam int OUT_BYTES_DEF = 4;
    localparam int PACK_MAX      = 4;
    localparam int CNT_W         = $clog2(PACK_MAX + 1);
    localparam int STORE_DEPTH   = 128;

    localparam logic       MODE_DECODE = 1'b0;
    localparam logic       MODE_ENCODE = 1'b1;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEC_RUN  = 2'd1;
    localparam logic [1:0] PH_DEC_LIT  = 2'd2;
    localparam logic [1:0] PH_ENC_LIT  = 2'd1;
    localparam logic [1:0] PH_ENC_RUN  = 2'd2;

    localparam logic [7:0] RUN_FLAG    = 8'h80;
    localparam logic [7:0] RUN_FULL    = 8'hFF;
    localparam logic [6:0] MAX_CHUNK   = 7'd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_REP,
        ST_LIT_RD,
        ST_LIT_PUSH,
        ST_FIN
    } seq_state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       close;
        logic       block_done;
        logic       malformed;
    } pack_ctl_t;

    typedef struct packed {
        logic push_ok;
        logic close_ok;
    } pack_sts_t;

endpackage

>>> hdl/run_length_byte_codec_top.sv
// run-length byte codec: control, byte sequencer and literal store
// an item runs through the sequencer: an optional header byte, then repeated
// bytes or literal bytes read back from the store (a read state before each push,
// as the ram read is registered), then a close; a result word waiting on
// out_ready stalls the sequencer
// reset: control state cleared, mode decode; the literal store is not cleared
module run_length_byte_codec_top #(
    parameter int OUT_BYTES = rlbc_pkg::OUT_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       block_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte0,
    output logic [7:0]                 out_byte1,
    output logic [7:0]                 out_byte2,
    output logic [7:0]                 out_byte3,
    output logic [rlbc_pkg::CNT_W-1:0] byte_count,
    output logic                       malformed,
    output logic                       block_done,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_mode
);
    import rlbc_pkg::*;

    localparam int PER = (OUT_BYTES > PACK_MAX) ? PACK_MAX : ((OUT_BYTES < 1) ? 1 : OUT_BYTES);
    localparam int AW  = $clog2(STORE_DEPTH);

    seq_state_t state_reg, state_next;

    // codec state
    logic          mode_reg;
    logic [1:0]    phase_reg, phase_plan;
    logic [6:0]    pending_reg, pending_plan;
    logic [7:0]    run_value_reg, run_value_plan;
    logic [6:0]    run_len_reg, run_len_plan;
    logic [7:0]    prev_reg, prev_plan;

    // per-word emission plan
    logic          p_hdr_en;
    logic [7:0]    p_hdr;
    logic [6:0]    p_cnt;
    logic [7:0]    p_rep;
    logic          p_lit;
    logic          p_wr;
    logic [AW-1:0] p_wr_addr;
    logic          p_bad;

    logic [7:0]    hdr_reg, hdr_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [7:0]    rep_reg, rep_next;
    logic          lit_reg, lit_next;
    logic          wr_en_reg, wr_en_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]    wdata_reg, wdata_next;
    logic          end_reg, end_next;
    logic          bad_reg, bad_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          in_acc;
    logic          cfg_acc;
    logic          ram_wr;
    logic [7:0]    rd_data;
    pack_ctl_t     pctl;
    pack_sts_t     psts;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;

    // work out what this word emits and how the codec state moves
    always_comb
    begin
        phase_plan     = phase_reg;
        pending_plan   = pending_reg;
        run_value_plan = run_value_reg;
        run_len_plan   = run_len_reg;
        prev_plan      = prev_reg;
        p_hdr_en       = 1'b0;
        p_hdr          = 8'd0;
        p_cnt          = 7'd0;
        p_rep          = in_byte;
        p_lit          = 1'b0;
        p_wr           = 1'b0;
        p_wr_addr      = '0;
        p_bad          = 1'b0;

        if (block_end)
        begin
            if (mode_reg == MODE_DECODE)
            begin
                p_bad = (phase_reg != PH_IDLE);
            end
            else if (phase_reg == PH_ENC_LIT && pending_reg != 7'd0)
            begin
                p_hdr_en = 1'b1;
                p_hdr    = {1'b0, pending_reg};
                p_cnt    = pending_reg;
                p_lit    = 1'b1;
            end
            else if (phase_reg == PH_ENC_RUN && run_len_reg != 7'd0)
            begin
                p_hdr_en = 1'b1;
                p_hdr    = RUN_FLAG | {1'b0, run_len_reg};
                p_cnt    = 7'd1;
                p_rep    = run_value_reg;
            end
            phase_plan     = PH_IDLE;
            pending_plan   = 7'd0;
            run_value_plan = 8'd0;
            run_len_plan   = 7'd0;
        end
        else if (mode_reg == MODE_DECODE)
        begin
            if (phase_reg == PH_DEC_RUN)
            begin
                p_cnt        = run_len_reg;
                phase_plan   = PH_IDLE;
                run_len_plan = 7'd0;
            end
            else if (phase_reg == PH_DEC_LIT && pending_reg != 7'd0)
            begin
                p_cnt        = 7'd1;
                pending_plan = pending_reg - 7'd1;
                if (pending_reg == 7'd1)
                begin
                    phase_plan = PH_IDLE;
                end
            end
            else
            begin
                // control word, also the path for the unused phase
                pending_plan = 7'd0;
                run_len_plan = 7'd0;
                phase_plan   = PH_IDLE;
                if (in_byte[7])
                begin
                    run_len_plan = in_byte[6:0];
                    phase_plan   = PH_DEC_RUN;
                end
                else if (in_byte[6:0] != 7'd0)
                begin
                    pending_plan = in_byte[6:0];
                    phase_plan   = PH_DEC_LIT;
                end
            end
        end
        else
        begin
            if (phase_reg == PH_ENC_LIT && pending_reg != 7'd0)
            begin
                if (in_byte == prev_reg)
                begin
                    // equal pair opens a run, earlier literals go out first
                    if (pending_reg > 7'd1)
                    begin
                        p_hdr_en = 1'b1;
                        p_hdr    = {1'b0, pending_reg - 7'd1};
                        p_cnt    = pending_reg - 7'd1;
                        p_lit    = 1'b1;
                    end
                    pending_plan   = 7'd0;
                    run_value_plan = in_byte;
                    run_len_plan   = 7'd2;
                    phase_plan     = PH_ENC_RUN;
                end
                else if (pending_reg == MAX_CHUNK)
                begin
                    p_hdr_en     = 1'b1;
                    p_hdr        = {1'b0, MAX_CHUNK};
                    p_cnt        = MAX_CHUNK;
                    p_lit        = 1'b1;
                    p_wr         = 1'b1;
                    p_wr_addr    = '0;
                    pending_plan = 7'd1;
                end
                else
                begin
                    p_wr         = 1'b1;
                    p_wr_addr    = pending_reg;
                    pending_plan = pending_reg + 7'd1;
                end
            end
            else if (phase_reg == PH_ENC_RUN && run_len_reg != 7'd0)
            begin
                if (in_byte == run_value_reg)
                begin
                    if (run_len_reg == MAX_CHUNK)
                    begin
                        p_hdr_en     = 1'b1;
                        p_hdr        = RUN_FULL;
                        p_cnt        = 7'd1;
                        run_len_plan = 7'd1;
                    end
                    else
                    begin
                        run_len_plan = run_len_reg + 7'd1;
                    end
                end
                else
                begin
                    p_hdr_en     = 1'b1;
                    p_hdr        = RUN_FLAG | {1'b0, run_len_reg};
                    p_cnt        = 7'd1;
                    p_rep        = run_value_reg;
                    run_len_plan = 7'd0;
                    p_wr         = 1'b1;
                    p_wr_addr    = '0;
                    pending_plan = 7'd1;
                    phase_plan   = PH_ENC_LIT;
                end
            end
            else
            begin
                run_len_plan = 7'd0;
                p_wr         = 1'b1;
                p_wr_addr    = '0;
                pending_plan = 7'd1;
                phase_plan   = PH_ENC_LIT;
            end
            if (p_wr)
            begin
                prev_plan = in_byte;
            end
        end
    end

    // byte sequencer
    always_comb
    begin
        state_next   = state_reg;
        hdr_next     = hdr_reg;
        cnt_next     = cnt_reg;
        rep_next     = rep_reg;
        lit_next     = lit_reg;
        wr_en_next   = wr_en_reg;
        wr_addr_next = wr_addr_reg;
        wdata_next   = wdata_reg;
        end_next     = end_reg;
        bad_next     = bad_reg;
        idx_next     = idx_reg;
        ram_wr       = 1'b0;

        pctl.push       = 1'b0;
        pctl.push_byte  = rep_reg;
        pctl.close      = 1'b0;
        pctl.block_done = end_reg;
        pctl.malformed  = bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    hdr_next     = p_hdr;
                    cnt_next     = p_cnt;
                    rep_next     = p_rep;
                    lit_next     = p_lit;
                    wr_en_next   = p_wr;
                    wr_addr_next = p_wr_addr;
                    wdata_next   = in_byte;
                    end_next     = block_end;
                    bad_next     = p_bad;
                    idx_next     = '0;
                    if (p_hdr_en)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (p_cnt != 7'd0)
                    begin
                        state_next = ST_REP;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_HDR:
            begin
                pctl.push      = 1'b1;
                pctl.push_byte = hdr_reg;
                if (psts.push_ok)
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (lit_reg)
                    begin
                        state_next = ST_LIT_RD;
                    end
                    else
                    begin
                        state_next = ST_REP;
                    end
                end
            end
            ST_REP:
            begin
                pctl.push      = 1'b1;
                pctl.push_byte = rep_reg;
                if (psts.push_ok)
                begin
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LIT_RD:
            begin
                state_next = ST_LIT_PUSH;
            end
            ST_LIT_PUSH:
            begin
                pctl.push      = 1'b1;
                pctl.push_byte = rd_data;
                if (psts.push_ok)
                begin
                    idx_next = idx_reg + AW'(1);
                    cnt_next = cnt_reg - 7'd1;
                    state_next = (cnt_reg == 7'd1) ? ST_FIN : ST_LIT_RD;
                end
            end
            ST_FIN:
            begin
                pctl.close = 1'b1;
                if (psts.close_ok)
                begin
                    // store write waits until literal reads are done
                    ram_wr     = wr_en_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_DECODE;
            phase_reg     <= PH_IDLE;
            pending_reg   <= 7'd0;
            run_value_reg <= 8'd0;
            run_len_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                mode_reg      <= cfg_mode;
                phase_reg     <= PH_IDLE;
                pending_reg   <= 7'd0;
                run_value_reg <= 8'd0;
                run_len_reg   <= 7'd0;
            end
            else if (in_acc)
            begin
                phase_reg     <= phase_plan;
                pending_reg   <= pending_plan;
                run_value_reg <= run_value_plan;
                run_len_reg   <= run_len_plan;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            prev_reg <= prev_plan;
        end
        hdr_reg     <= hdr_next;
        cnt_reg     <= cnt_next;
        rep_reg     <= rep_next;
        lit_reg     <= lit_next;
        wr_en_reg   <= wr_en_next;
        wr_addr_reg <= wr_addr_next;
        wdata_reg   <= wdata_next;
        end_reg     <= end_next;
        bad_reg     <= bad_next;
        idx_reg     <= idx_next;
    end

    rlbc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (wr_addr_reg),
        .wr_data (wdata_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    rlbc_pack #(
        .PER (PER)
    ) u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pctl),
        .sts        (psts),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_byte0  (out_byte0),
        .out_byte1  (out_byte1),
        .out_byte2  (out_byte2),
        .out_byte3  (out_byte3),
        .byte_count (byte_count),
        .malformed  (malformed),
        .block_done (block_done),
        .last       (last)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> last)
        else $error("block done result not marked last");

    a_malformed_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |-> block_done)
        else $error("malformed flag outside block done result");

    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_count == CNT_W'(PER))
        else $error("partial result word before the last one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new word taken while previous one still in work");

endmodule

>>> hdl/rlbc_ram.sv
// generic single-write, single-read ram with registered read data
module rlbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/rlbc_pack.sv
// output byte packer with the result word register
module rlbc_pack #(
    parameter int PER = rlbc_pkg::OUT_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rlbc_pkg::pack_ctl_t    ctl,
    output rlbc_pkg::pack_sts_t    sts,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             out_byte0,
    output logic [7:0]             out_byte1,
    output logic [7:0]             out_byte2,
    output logic [7:0]             out_byte3,
    output logic [rlbc_pkg::CNT_W-1:0] byte_count,
    output logic                   malformed,
    output logic                   block_done,
    output logic                   last
);
    import rlbc_pkg::*;

    localparam int IDX_W = $clog2(PACK_MAX);
    localparam logic [CNT_W-1:0] PER_CNT = CNT_W'(PER);

    logic [7:0]       pack_reg [PACK_MAX];
    logic [7:0]       pack_next [PACK_MAX];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       obyte_reg [PACK_MAX];
    logic [7:0]       obyte_next [PACK_MAX];
    logic [CNT_W-1:0] ocount_reg, ocount_next;
    logic             omal_reg, omal_next;
    logic             odone_reg, odone_next;
    logic             olast_reg, olast_next;

    logic out_free;
    logic full;
    logic close_need;
    logic load;

    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        full       = (cnt_reg == PER_CNT);
        close_need = ctl.block_done || (cnt_reg != '0);

        sts.push_ok  = !full || out_free;
        sts.close_ok = !close_need || out_free;

        load = (ctl.push && full && out_free) || (ctl.close && close_need && out_free);

        pack_next = pack_reg;
        cnt_next  = cnt_reg;
        if (ctl.push && sts.push_ok)
        begin
            if (full)
            begin
                pack_next[0] = ctl.push_byte;
                cnt_next     = CNT_W'(1);
            end
            else
            begin
                pack_next[cnt_reg[IDX_W-1:0]] = ctl.push_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (ctl.close && sts.close_ok)
        begin
            cnt_next = '0;
        end

        // unused slots of a result read as zero
        for (int j = 0; j < PACK_MAX; j++)
        begin
            obyte_next[j] = (CNT_W'(j) < cnt_reg) ? pack_reg[j] : 8'd0;
        end
        ocount_next = cnt_reg;
        olast_next  = ctl.close;
        odone_next  = ctl.close && ctl.block_done;
        omal_next   = ctl.close && ctl.block_done && ctl.malformed;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
        if (load)
        begin
            obyte_reg  <= obyte_next;
            ocount_reg <= ocount_next;
            omal_reg   <= omal_next;
            odone_reg  <= odone_next;
            olast_reg  <= olast_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte0  = obyte_reg[0];
    assign out_byte1  = obyte_reg[1];
    assign out_byte2  = obyte_reg[2];
    assign out_byte3  = obyte_reg[3];
    assign byte_count = ocount_reg;
    assign malformed  = omal_reg;
    assign block_done = odone_reg;
    assign last       = olast_reg;

endmodule
